>>> rtl/mfng_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfng_pkg: shared constants and types of the most frequent n-gram unit
// Sizes of the count table, tag epochs, stage and result structures.
// ----------------------------------------------------------------------------
package mfng_pkg;

   localparam int MAX_TEXT    = 128;
   localparam int SYMBOL_BITS = 8;
   localparam int BYTE_BITS   = 8;
   localparam int IDX_BITS    = 2 * SYMBOL_BITS;
   localparam int TABLE_DEPTH = 1 << IDX_BITS;
   localparam int POS_BITS    = $clog2(MAX_TEXT + 1);
   localparam int COUNT_BITS  = 8;
   localparam int EPOCH_BITS  = 8;
   localparam int WORD_BITS   = EPOCH_BITS + COUNT_BITS;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
   localparam logic [EPOCH_BITS-1:0] EPOCH_MAX  = '1;
   localparam logic [BYTE_BITS-1:0]  SPACE_CODE = 8'h20;

   localparam logic MODE_UNIGRAM = 1'b0;
   localparam logic MODE_BIGRAM  = 1'b1;

   typedef struct packed {
      logic                valid;
      logic                bump;
      logic                last;
      logic                mode;
      logic [IDX_BITS-1:0] addr;
   } stage_type;

   typedef struct packed {
      logic                  en;
      logic [IDX_BITS-1:0]   addr;
      logic [COUNT_BITS-1:0] count;
      logic                  text_done;
   } table_write_type;

   typedef struct packed {
      logic busy;
      logic epoch_full;
   } table_status_type;

   typedef struct packed {
      logic [BYTE_BITS-1:0]  gram_first;
      logic [BYTE_BITS-1:0]  gram_second;
      logic [COUNT_BITS-1:0] frequency;
      logic                  found;
   } result_type;

endpackage
`default_nettype wire

>>> rtl/mfng_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfng_if: channel interfaces of the most frequent n-gram unit
// Text byte requests, result responses and the mode register write channel.
// ----------------------------------------------------------------------------
interface mfng_req_if
   import mfng_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [BYTE_BITS-1:0] symbol;
   logic                 last;

   modport source (output valid, output symbol, output last, input ready);
   modport sink   (input valid, input symbol, input last, output ready);
endinterface

interface mfng_rsp_if
   import mfng_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [BYTE_BITS-1:0]  gram_first;
   logic [BYTE_BITS-1:0]  gram_second;
   logic [COUNT_BITS-1:0] frequency;
   logic                  found;

   modport source (output valid, output gram_first, output gram_second,
                   output frequency, output found, input ready);
   modport sink   (input valid, input gram_first, input gram_second,
                   input frequency, input found, output ready);
endinterface

interface mfng_csr_if;
   logic valid;
   logic ready;
   logic mode;

   modport source (output valid, output mode, input ready);
   modport sink   (input valid, input mode, output ready);
endinterface
`default_nettype wire

>>> rtl/most_frequent_ngram_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// most_frequent_ngram_unit: most frequent character or character pair
// Counts unigrams or bigrams of a byte stream and reports the leader per text.
// ----------------------------------------------------------------------------
// The unit takes one text byte per cycle unless it holds off the input, and
// returns one response transaction per text once the byte flagged last has
// passed the stage register and the response queue. Each byte does one
// read-modify-write of its 8-bit counter in a 65536-entry memory (read in the
// accept cycle, written back the next, forwarded when the next byte hits the
// same counter). Counters carry an 8-bit text epoch tag, so no clearing is
// needed between texts. After reset a clearing pass over all 65536 entries
// runs during which no byte is taken. The last byte of every 256th text holds
// off the input while it is in flight, and then another clearing pass runs. A
// byte is also held off while the two-entry response queue is full, and while
// a last byte is in flight and the queue already holds one result. The mode
// register is written through the csr channel, which is always ready.
module most_frequent_ngram_unit
   import mfng_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   mfng_req_if.sink    req_bus,
   mfng_rsp_if.source  rsp_bus,
   mfng_csr_if.sink    csr_bus
);

   logic                  mode_ff, mode_in;
   logic                  req_fire;
   logic                  rd_en;
   logic [IDX_BITS-1:0]   rd_addr;
   logic [COUNT_BITS-1:0] rd_count;
   stage_type             stage;
   table_write_type       wr;
   table_status_type      status;
   logic                  push;
   result_type            result;
   logic [1:0]            q_count;
   logic                  s1_last;
   logic                  q_block;

   assign csr_bus.ready = 1'b1;
   assign mode_in       = (csr_bus.valid && csr_bus.ready) ? csr_bus.mode : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_UNIGRAM;
      end else begin
         mode_ff <= mode_in;
      end
   end

   assign s1_last  = stage.valid && stage.last;
   assign q_block  = (q_count == 2'd2) || ((q_count == 2'd1) && s1_last);
   assign req_bus.ready = !status.busy && !q_block && !(s1_last && status.epoch_full);
   assign req_fire = req_bus.valid && req_bus.ready;

   mfng_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .symbol   (req_bus.symbol),
      .last     (req_bus.last),
      .mode     (mode_ff),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .stage_ff (stage)
   );

   mfng_table u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .wr       (wr),
      .rd_count (rd_count),
      .status   (status)
   );

   mfng_rank u_rank (
      .clock    (clock),
      .reset    (reset),
      .stage    (stage),
      .rd_count (rd_count),
      .wr       (wr),
      .push     (push),
      .result   (result)
   );

   mfng_rspq u_rspq (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .data  (result),
      .count (q_count),
      .rsp   (rsp_bus)
   );

`ifndef SYNTHESIS
   a_last_pushes: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_bus.last) |=> push)
      else $error("last byte did not produce a result");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (q_count != 2'd2))
      else $error("result pushed into a full response queue");

   a_sweep_idle: assert property (@(posedge clock) disable iff (reset)
      status.busy |-> !stage.valid)
      else $error("byte in flight during clearing pass");
`endif

endmodule
`default_nettype wire

>>> rtl/mfng_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfng_front: text tracking and table address generation
// Holds the previous symbol and byte position, forms the gram code.
// ----------------------------------------------------------------------------
module mfng_front
   import mfng_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_fire,
   input  wire logic [BYTE_BITS-1:0]  symbol,
   input  wire logic                  last,
   input  wire logic                  mode,
   output      logic                  rd_en,
   output      logic [IDX_BITS-1:0]   rd_addr,
   output      stage_type             stage_ff
);

   logic [SYMBOL_BITS-1:0] prev_ff, prev_in;
   logic                   prev_valid_ff, prev_valid_in;
   logic [POS_BITS-1:0]    pos_ff, pos_in;
   stage_type              stage_in;

   logic [SYMBOL_BITS-1:0] code;
   logic                   space;
   logic                   in_range;
   logic [IDX_BITS-1:0]    addr;

   assign code     = symbol[SYMBOL_BITS-1:0];
   assign space    = (symbol == SPACE_CODE);
   assign in_range = (pos_ff < POS_BITS'(MAX_TEXT));
   assign addr     = (mode == MODE_BIGRAM) ? {prev_ff, code}
                                           : {{SYMBOL_BITS{1'b0}}, code};

   assign rd_en   = req_fire;
   assign rd_addr = addr;

   always_comb begin
      prev_in       = prev_ff;
      prev_valid_in = prev_valid_ff;
      pos_in        = pos_ff;
      stage_in.valid = req_fire;
      stage_in.bump  = in_range && !space && ((mode == MODE_UNIGRAM) || prev_valid_ff);
      stage_in.last  = last;
      stage_in.mode  = mode;
      stage_in.addr  = addr;
      if (req_fire) begin
         if (last) begin
            prev_in       = '0;
            prev_valid_in = 1'b0;
            pos_in        = '0;
         end else if (in_range) begin
            prev_in       = code;
            prev_valid_in = !space;
            pos_in        = pos_ff + POS_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff       <= '0;
         prev_valid_ff <= 1'b0;
         pos_ff        <= '0;
         stage_ff      <= '0;
      end else begin
         prev_ff       <= prev_in;
         prev_valid_ff <= prev_valid_in;
         pos_ff        <= pos_in;
         stage_ff      <= stage_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/mfng_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfng_table: gram count memory with epoch tags
// One read and one write port, write-to-read forwarding, clearing sweep.
// ----------------------------------------------------------------------------
module mfng_table
   import mfng_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  rd_en,
   input  wire logic [IDX_BITS-1:0]   rd_addr,
   input  wire table_write_type       wr,
   output      logic [COUNT_BITS-1:0] rd_count,
   output      table_status_type      status
);

   logic [WORD_BITS-1:0]  mem [TABLE_DEPTH];
   logic [WORD_BITS-1:0]  rd_word_ff;
   logic [WORD_BITS-1:0]  fwd_word_ff, fwd_word_in;
   logic                  fwd_ff, fwd_in;
   logic                  sweep_ff, sweep_in;
   logic [IDX_BITS-1:0]   sweep_idx_ff, sweep_idx_in;
   logic [EPOCH_BITS-1:0] epoch_ff, epoch_in;

   logic                  mem_we;
   logic [IDX_BITS-1:0]   mem_wa;
   logic [WORD_BITS-1:0]  mem_wd;
   logic [WORD_BITS-1:0]  sel_word;

   assign mem_we = sweep_ff || wr.en;
   assign mem_wa = sweep_ff ? sweep_idx_ff : wr.addr;
   assign mem_wd = sweep_ff ? '0 : {epoch_ff, wr.count};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rd_word_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      fwd_in       = fwd_ff;
      fwd_word_in  = fwd_word_ff;
      sweep_in     = sweep_ff;
      sweep_idx_in = sweep_idx_ff;
      epoch_in     = epoch_ff;
      if (rd_en) begin
         fwd_in      = mem_we && (mem_wa == rd_addr);
         fwd_word_in = mem_wd;
      end
      if (sweep_ff) begin
         sweep_idx_in = sweep_idx_ff + IDX_BITS'(1);
         if (sweep_idx_ff == '1) begin
            sweep_in = 1'b0;
         end
      end
      if (wr.text_done) begin
         epoch_in = epoch_ff + EPOCH_BITS'(1);
         if (epoch_ff == EPOCH_MAX) begin
            sweep_in     = 1'b1;
            sweep_idx_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff       <= 1'b0;
         sweep_ff     <= 1'b1;
         sweep_idx_ff <= '0;
         epoch_ff     <= '0;
      end else begin
         fwd_ff       <= fwd_in;
         sweep_ff     <= sweep_in;
         sweep_idx_ff <= sweep_idx_in;
         epoch_ff     <= epoch_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_word_ff <= fwd_word_in;
   end

   assign sel_word = fwd_ff ? fwd_word_ff : rd_word_ff;
   assign rd_count = (sel_word[WORD_BITS-1:COUNT_BITS] == epoch_ff)
                   ? sel_word[COUNT_BITS-1:0] : '0;

   assign status.busy       = sweep_ff;
   assign status.epoch_full = (epoch_ff == EPOCH_MAX);

endmodule
`default_nettype wire

>>> rtl/mfng_rank.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfng_rank: count increment and running best
// Saturating increment, write back, best gram tracking and result decode.
// ----------------------------------------------------------------------------
module mfng_rank
   import mfng_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire stage_type             stage,
   input  wire logic [COUNT_BITS-1:0] rd_count,
   output      table_write_type       wr,
   output      logic                  push,
   output      result_type            result
);

   logic [COUNT_BITS-1:0] best_count_ff, best_count_in, best_count_nxt;
   logic [IDX_BITS-1:0]   best_gram_ff, best_gram_in, best_gram_nxt;
   logic [COUNT_BITS-1:0] count_new;
   logic                  bump;
   logic                  take;

   assign bump      = stage.valid && stage.bump;
   assign count_new = (rd_count == COUNT_MAX) ? COUNT_MAX : rd_count + COUNT_BITS'(1);
   assign take      = bump && ((count_new > best_count_ff) ||
                               ((count_new == best_count_ff) && (stage.addr < best_gram_ff)));

   assign best_count_nxt = take ? count_new : best_count_ff;
   assign best_gram_nxt  = take ? stage.addr : best_gram_ff;

   assign wr.en        = bump;
   assign wr.addr      = stage.addr;
   assign wr.count     = count_new;
   assign wr.text_done = stage.valid && stage.last;
   assign push         = wr.text_done;

   always_comb begin
      result = '0;
      if (best_count_nxt != '0) begin
         result.found     = 1'b1;
         result.frequency = best_count_nxt;
         unique case (stage.mode)
            MODE_UNIGRAM: begin
               result.gram_first = best_gram_nxt[BYTE_BITS-1:0];
            end
            MODE_BIGRAM: begin
               result.gram_first  = BYTE_BITS'(best_gram_nxt[IDX_BITS-1:SYMBOL_BITS]);
               result.gram_second = BYTE_BITS'(best_gram_nxt[SYMBOL_BITS-1:0]);
            end
            default: begin
               result = '0;
            end
         endcase
      end
   end

   always_comb begin
      best_count_in = best_count_nxt;
      best_gram_in  = best_gram_nxt;
      if (wr.text_done) begin
         best_count_in = '0;
         best_gram_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_count_ff <= '0;
         best_gram_ff  <= '0;
      end else begin
         best_count_ff <= best_count_in;
         best_gram_ff  <= best_gram_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/mfng_rspq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfng_rspq: response queue
// Two-entry queue between the result stage and the response channel.
// ----------------------------------------------------------------------------
module mfng_rspq
   import mfng_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire result_type data,
   output      logic [1:0] count,
   mfng_rsp_if.source      rsp
);

   result_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;
   result_type head;

   assign pop  = rsp.valid && rsp.ready;
   assign head = entry_ff[rd_ptr_ff];

   assign rsp.valid       = (count_ff != 2'd0);
   assign rsp.gram_first  = head.gram_first;
   assign rsp.gram_second = head.gram_second;
   assign rsp.frequency   = head.frequency;
   assign rsp.found       = head.found;
   assign count           = count_ff;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

>>> sim/tb_most_frequent_ngram_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_most_frequent_ngram_unit: self-checking bench of the n-gram frequency unit
// Streams short texts and some at or past the length cap in both counting modes
// Random idle bursts on both channels and one long response hold-off apply.
// ----------------------------------------------------------------------------
module tb_most_frequent_ngram_unit;
   import mfng_pkg::*;

   localparam int          HALF_PERIOD   = 6;
   localparam int          PHASE_ITEMS   = 360;
   localparam int          HOLD_CYCLES   = 600;
   localparam int          SETTLE_CYCLES = 8;
   localparam int unsigned TIMEOUT_NS    = 40_000_000;

   typedef struct {
      logic [BYTE_BITS-1:0] symbol;
      logic                 last;
   } text_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mfng_req_if req_bus ();
   mfng_rsp_if rsp_bus ();
   mfng_csr_if csr_bus ();

   most_frequent_ngram_unit i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // stimulus and checking state
   text_byte_type          byte_q [$];
   text_byte_type          next_byte;
   result_type             leader_q [$];
   bit                     req_fire;
   bit                     calm = 1'b0;
   bit                     hold_go = 1'b0;
   logic                   rsp_hold = 1'b0;
   int unsigned            send_gap;
   int unsigned            take_gap;
   int unsigned            bytes_queued;
   int unsigned            bytes_taken;
   int unsigned            texts_queued;
   int unsigned            overlong_texts;
   int unsigned            miss_count;
   int unsigned            results_checked;
   int unsigned            unigram_results;
   int unsigned            bigram_results;
   int unsigned            empty_results;

   // predictor state
   logic                   mode_q = MODE_UNIGRAM;
   logic [COUNT_BITS-1:0]  gram_tally [logic [IDX_BITS-1:0]];
   logic [SYMBOL_BITS-1:0] prev_sym;
   logic                   prev_ok;
   logic [IDX_BITS-1:0]    lead_gram;
   logic [COUNT_BITS-1:0]  lead_count;
   int unsigned            text_pos;

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   function automatic void note_mismatch(input string msg);
      miss_count++;
      if (miss_count <= 10) begin
         $display("MISMATCH at %0t: %s", $realtime, msg);
      end
   endfunction

   function automatic void tally_gram(input logic [IDX_BITS-1:0] idx);
      logic [COUNT_BITS-1:0] c;
      c = gram_tally.exists(idx) ? gram_tally[idx] : '0;
      if (c != COUNT_MAX) c++;
      gram_tally[idx] = c;
      if (c > lead_count || (c == lead_count && idx < lead_gram)) begin
         lead_count = c;
         lead_gram  = idx;
      end
   endfunction

   function automatic void absorb_byte(input logic [BYTE_BITS-1:0] sym, input logic is_last);
      logic [SYMBOL_BITS-1:0] code;
      logic                   is_space;
      result_type             r;
      code     = sym[SYMBOL_BITS-1:0];
      is_space = (sym == SPACE_CODE);
      if (text_pos < MAX_TEXT) begin
         text_pos++;
         if (!is_space) begin
            if (mode_q == MODE_UNIGRAM) begin
               tally_gram(IDX_BITS'(code));
            end else if (prev_ok) begin
               tally_gram({prev_sym, code});
            end
         end
         prev_sym = code;
         prev_ok  = !is_space;
      end
      if (is_last) begin
         r = '0;
         if (lead_count != 0) begin
            r.found     = 1'b1;
            r.frequency = lead_count;
            if (mode_q == MODE_UNIGRAM) begin
               r.gram_first = lead_gram[BYTE_BITS-1:0];
            end else begin
               r.gram_first  = BYTE_BITS'(lead_gram[IDX_BITS-1 -: SYMBOL_BITS]);
               r.gram_second = BYTE_BITS'(lead_gram[SYMBOL_BITS-1:0]);
            end
         end
         leader_q.push_back(r);
         gram_tally.delete();
         prev_sym   = '0;
         prev_ok    = 1'b0;
         lead_gram  = '0;
         lead_count = '0;
         text_pos   = 0;
      end
   endfunction

   function automatic void check_result();
      result_type want;
      result_type got;
      got.gram_first  = rsp_bus.gram_first;
      got.gram_second = rsp_bus.gram_second;
      got.frequency   = rsp_bus.frequency;
      got.found       = rsp_bus.found;
      if (leader_q.size() == 0) begin
         note_mismatch($sformatf("result with none expected: gram %02h %02h freq %0d found %0b",
                                 got.gram_first, got.gram_second, got.frequency, got.found));
         return;
      end
      want = leader_q.pop_front();
      results_checked++;
      if (!want.found) empty_results++;
      else if (mode_q == MODE_BIGRAM) bigram_results++;
      else unigram_results++;
      if (got.gram_first !== want.gram_first || got.gram_second !== want.gram_second ||
          got.frequency !== want.frequency || got.found !== want.found) begin
         note_mismatch($sformatf(
            "result %0d: expected gram %02h %02h freq %0d found %0b, got %02h %02h %0d %0b",
            results_checked, want.gram_first, want.gram_second, want.frequency, want.found,
            got.gram_first, got.gram_second, got.frequency, got.found));
      end
   endfunction

   // monitor: sample every transaction at the rising edge
   always @(posedge clock) begin
      req_fire = !reset && req_bus.valid && req_bus.ready;
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) mode_q = csr_bus.mode;
         if (rsp_bus.valid && rsp_bus.ready) check_result();
         if (req_fire) begin
            bytes_taken++;
            absorb_byte(req_bus.symbol, req_bus.last);
         end
      end
   end

   // driver: advance on acceptance, insert idle bursts
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_fire) begin
         if (!calm && send_gap == 0 && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(1, 9);
         end
         if (send_gap != 0 || byte_q.size() == 0) begin
            if (send_gap != 0) send_gap--;
            req_bus.valid <= 1'b0;
         end else begin
            next_byte = byte_q.pop_front();
            req_bus.valid  <= 1'b1;
            req_bus.symbol <= next_byte.symbol;
            req_bus.last   <= next_byte.last;
         end
      end
   end

   // receiver: stall in bursts, hold off while requested
   always @(negedge clock) begin
      if (reset || rsp_hold) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (!calm && take_gap == 0 && $urandom_range(0, 5) == 0) begin
            take_gap = $urandom_range(1, 9);
         end
         if (take_gap != 0) begin
            take_gap--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // long response hold-off so the input backs up
   initial begin
      wait (hold_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("tb_most_frequent_ngram_unit NOT OK");
      $finish;
   end

   function automatic void push_byte(input logic [BYTE_BITS-1:0] sym, input logic is_last);
      text_byte_type b;
      b.symbol = sym;
      b.last   = is_last;
      byte_q.push_back(b);
      bytes_queued++;
      if (is_last) texts_queued++;
   endfunction

   function automatic void queue_word(input string s);
      for (int i = 0; i < s.len(); i++) begin
         push_byte(s[i], i == s.len() - 1);
      end
   endfunction

   function automatic logic [BYTE_BITS-1:0] draw_symbol(input int unsigned style,
                                                        input logic [BYTE_BITS-1:0] base);
      if (style < 60) begin
         if ($urandom_range(0, 6) == 0) return SPACE_CODE;
         return base + BYTE_BITS'($urandom_range(0, 3));
      end else if (style < 85) begin
         if ($urandom_range(0, 9) == 0) return SPACE_CODE;
         return BYTE_BITS'($urandom_range(0, 255));
      end
      if ($urandom_range(0, 2) != 0) return base;
      return BYTE_BITS'($urandom_range(0, 255));
   endfunction

   function automatic void queue_text(input int unsigned len);
      int unsigned          style;
      logic [BYTE_BITS-1:0] base;
      style = $urandom_range(0, 99);
      base  = BYTE_BITS'($urandom_range(0, 252));
      for (int unsigned n = 0; n < len; n++) begin
         push_byte(draw_symbol(style, base), n == len - 1);
      end
   endfunction

   function automatic int unsigned pick_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 4);
      if (r < 95) return $urandom_range(5, 16);
      return $urandom_range(17, 40);
   endfunction

   task automatic write_mode(input logic value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.mode  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic settle();
      while (bytes_taken != bytes_queued || leader_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      int unsigned phase_start;
      req_bus.valid  = 1'b0;
      req_bus.symbol = '0;
      req_bus.last   = 1'b0;
      rsp_bus.ready  = 1'b0;
      csr_bus.valid  = 1'b0;
      csr_bus.mode   = MODE_UNIGRAM;
      prev_sym       = '0;
      prev_ok        = 1'b0;
      lead_gram      = '0;
      lead_count     = '0;
      text_pos       = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // single characters: no gram, code extremes, tie on count
      write_mode(MODE_UNIGRAM);
      queue_word(" ");
      push_byte(8'h00, 1'b1);
      push_byte(8'hFF, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b1);
      queue_word("ba ab");
      settle();

      // pairs: lone byte, pairs broken by a space, extremes, tie order
      write_mode(MODE_BIGRAM);
      queue_word("q");
      queue_word("a b");
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(SPACE_CODE, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'hFF, 1'b1);
      queue_word("baab");

      for (int p = 0; p < 4; p++) begin
         settle();
         write_mode(p[0] ? MODE_BIGRAM : MODE_UNIGRAM);
         if (p == 3) calm = 1'b1;
         phase_start = bytes_queued;
         if (p % 2 == 0) begin
            queue_text($urandom_range(MAX_TEXT, MAX_TEXT + 12));
            overlong_texts++;
         end
         while (bytes_queued - phase_start < PHASE_ITEMS) queue_text(pick_length());
         if (p == 0) hold_go = 1'b1;
      end
      settle();

      if (leader_q.size() != 0) begin
         note_mismatch($sformatf("%0d results never arrived", leader_q.size()));
      end
      $display("Covered %0d texts, %0d bytes, %0d of them at or past the length cap.",
               texts_queued, bytes_taken, overlong_texts);
      $display("Checked %0d results: %0d unigram, %0d bigram, %0d empty; %0d mismatches.",
               results_checked, unigram_results, bigram_results, empty_results, miss_count);
      if (miss_count == 0) begin
         $display("tb_most_frequent_ngram_unit OK");
      end else begin
         $display("tb_most_frequent_ngram_unit NOT OK");
      end
      $finish;
   end

endmodule
